// ===== src/uatrc_pkg.sv =====
// uatrc_pkg: types, codes and constant tables for the uart receiver and reply classifier
// no dependencies; imported by every module of the block
`default_nettype none

package uatrc_pkg;

	localparam int LINE_MAX  = 16;
	localparam int LINE_CW   = $clog2(LINE_MAX + 1);
	localparam int LINE_IW   = $clog2(LINE_MAX);
	localparam int LEN_W     = 5;
	localparam int TICK_W    = 16;
	localparam int NUM_WORDS = 4;
	localparam int WORD_MAX  = 10;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 24;

	typedef logic [6:0] char_t;
	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [LINE_CW-1:0] count_t;

	localparam char_t CH_LF = 7'h0A;
	localparam char_t CH_CR = 7'h0D;

	localparam tick_t TPB_RESET   = 16'd98;
	localparam tick_t HALF_RESET  = 16'd49;
	localparam tick_t EXTRA_RESET = 16'd40;

	typedef enum logic [1:0] {
		REG_TICKS_PER_BIT    = 2'd0,
		REG_HALF_BIT_TICKS   = 2'd1,
		REG_STOP_EXTRA_TICKS = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HALF = 2'd1,
		PH_DATA = 2'd2,
		PH_STOP = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		CLS_OK         = 3'd0,
		CLS_CONNECT    = 3'd1,
		CLS_DISCONNECT = 3'd2,
		CLS_ERROR      = 3'd3,
		CLS_OTHER      = 3'd4
	} class_t;

	typedef struct packed {
		logic             ovf;
		logic [LEN_W-1:0] len;
		class_t           cls;
		logic             done;
		char_t            code;
		logic             bvalid;
	} res_t;

	// reply words, first character at index 0, padded with NUL
	localparam char_t WORD_TAB [NUM_WORDS][WORD_MAX] = '{
		'{7'h4F, 7'h4B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
		'{7'h43, 7'h4F, 7'h4E, 7'h4E, 7'h45, 7'h43, 7'h54, 7'h00, 7'h00, 7'h00},
		'{7'h44, 7'h49, 7'h53, 7'h43, 7'h4F, 7'h4E, 7'h4E, 7'h45, 7'h43, 7'h54},
		'{7'h45, 7'h52, 7'h52, 7'h4F, 7'h52, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
	};

	localparam count_t WORD_LEN [NUM_WORDS] = '{
		count_t'(2), count_t'(7), count_t'(10), count_t'(5)
	};

endpackage

`default_nettype wire

// ===== src/uart_rx_at_response_classifier.sv =====
// uart_rx_at_response_classifier: 8n1 receiver, line assembler and modem reply classifier
// depends on uatrc_pkg
//
// one input item is one timing tick carrying the sampled rx pin in s_tdata[0].
// a low level while idle starts a character; after half_bit_ticks the eight
// data bits are taken lsb first, ticks_per_bit apart, then one bit time plus
// stop_extra_ticks pass before the character is presented as one output item.
// ticks that complete no character produce no output item.
// line feed items close the stored line and carry its class, length and
// overflow flag; carriage returns are passed on but not stored.
// an item is taken in every cycle while s_tready is high: the tick state is registered,
// and the result lands in a two-entry output register (head plus skid), written into the
// head entry, or into the skid entry while the head holds an item not yet taken.
// s_tready drops only while both output entries are full.
// reset returns the receiver to idle, empties the line and the output entries,
// and loads the timing registers with 98, 49 and 40.
// configuration writes through cfg_we/cfg_addr/cfg_wdata take effect at once.
`default_nettype none

module uart_rx_at_response_classifier
	import uatrc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_addr,
	input  wire logic [TICK_W-1:0]   cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // rx_level, zero fill
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // byte_valid, char_code, line_class,
	                                           // line_length, line_overflow, zero fill
	output logic                     m_tlast   // line_done
);

	tick_t tpb_q, half_q, extra_q;

	phase_t       phase_q, phase_d;
	tick_t        tick_q, tick_d;
	logic [TICK_W:0] tick_inc;
	logic [2:0]   bit_q, bit_d;
	logic [7:0]   shift_q, shift_d;
	logic         emit;

	char_t        store_q [LINE_MAX];
	count_t       count_q;
	logic         ovf_q;

	res_t         res;
	res_t         head_q, skid_q;
	logic         head_vld_q, skid_vld_q;
	logic         acc, pop, push;
	logic         rx;
	char_t        c;
	logic         is_lf, is_cr;
	logic         word_hit [NUM_WORDS];
	class_t       cls;

	assign rx       = s_tdata[0];
	assign s_tready = !skid_vld_q;
	assign acc      = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;
	assign push     = acc && emit;
	assign c        = shift_q[6:0];
	assign is_lf    = (c == CH_LF);
	assign is_cr    = (c == CH_CR);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q   <= TPB_RESET;
			half_q  <= HALF_RESET;
			extra_q <= EXTRA_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TICKS_PER_BIT:    tpb_q   <= cfg_wdata;
				REG_HALF_BIT_TICKS:   half_q  <= cfg_wdata;
				REG_STOP_EXTRA_TICKS: extra_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		emit     = 1'b0;
		tick_inc = {1'b0, tick_q} + {{TICK_W{1'b0}}, 1'b1};
		case (phase_q)
			PH_IDLE: begin
				if (!rx) begin
					phase_d = PH_HALF;
					tick_d  = '0;
					bit_d   = '0;
					shift_d = '0;
				end
			end
			PH_HALF: begin
				tick_d = tick_inc[TICK_W-1:0];
				if (tick_inc >= {1'b0, half_q}) begin
					phase_d = PH_DATA;
					tick_d  = '0;
				end
			end
			PH_DATA: begin
				tick_d = tick_inc[TICK_W-1:0];
				if (tick_inc >= {1'b0, tpb_q}) begin
					tick_d         = '0;
					shift_d[bit_q] = shift_q[bit_q] | rx;
					bit_d          = bit_q + 3'd1;
					if (bit_q == 3'd7)
						phase_d = PH_STOP;
				end
			end
			PH_STOP: begin
				tick_d = tick_inc[TICK_W-1:0];
				if (bit_q == 3'd0) begin
					if (tick_inc >= {1'b0, tpb_q}) begin
						tick_d = '0;
						if (extra_q != '0)
							bit_d = 3'd1;
						else
							emit = 1'b1;
					end
				end else if (tick_inc >= {1'b0, extra_q}) begin
					emit = 1'b1;
				end
				if (emit) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
					bit_d   = '0;
					shift_d = '0;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
		end
	end

	// reply classification of the stored line
	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			word_hit[w] = (count_q == WORD_LEN[w]);
			for (int i = 0; i < WORD_MAX; i++) begin
				if ((count_t'(i) < WORD_LEN[w]) && (store_q[i] != WORD_TAB[w][i]))
					word_hit[w] = 1'b0;
			end
		end
		cls = CLS_OTHER;
		for (int w = NUM_WORDS - 1; w >= 0; w--) begin
			if (word_hit[w])
				cls = class_t'(3'(w));
		end
		if (ovf_q)
			cls = CLS_OTHER;
	end

	// result of a completed character
	always_comb begin
		res        = '0;
		res.bvalid = 1'b1;
		res.code   = c;
		if (is_lf) begin
			res.done = 1'b1;
			res.cls  = cls;
			res.len  = LEN_W'(count_q);
			res.ovf  = ovf_q;
		end
	end

	// line store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (push) begin
			if (is_lf) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (!is_cr) begin
				if (count_q < count_t'(LINE_MAX))
					count_q <= count_q + count_t'(1);
				else
					ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !is_lf && !is_cr && (count_q < count_t'(LINE_MAX)))
			store_q[count_q[LINE_IW-1:0]] <= c;
	end

	// output head and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			if (!head_vld_q)
				head_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q)
				head_q <= skid_q;
			else if (push)
				head_q <= res;
		end else if (push) begin
			if (!head_vld_q)
				head_q <= res;
			else
				skid_q <= res;
		end
	end

	assign m_tvalid = head_vld_q;
	assign m_tlast  = head_q.done;
	assign m_tdata  = {7'b0, head_q.ovf, head_q.len, head_q.cls, head_q.code, head_q.bvalid};

endmodule

`default_nettype wire

// ===== src/uatrc_checker.sv =====
// uatrc_checker: port-level assertions for the uart receiver and reply classifier
// depends on uatrc_pkg; bound to uart_rx_at_response_classifier below
`default_nettype none

module uatrc_checker
	import uatrc_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic                m_tlast
);

	// input side stalls only behind a waiting output item
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output item pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output item changed");

	// line end items are line feeds
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[0] && (m_tdata[7:1] == CH_LF))
		else $error("line end item is not a line feed");

	// overflowed lines are never a reply word, other items carry no line info
	a_line_info: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast ? (!m_tdata[16] || (m_tdata[10:8] == CLS_OTHER))
		                      : (m_tdata[16:8] == 9'd0)))
		else $error("bad line class or length fields");

endmodule

bind uart_rx_at_response_classifier uatrc_checker u_uatrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
